### hdl/nvtg_pkg.sv
package nvtg_pkg;

	// number format limits
	localparam int INTEGER_DIGITS  = 4;
	localparam int FRACTION_DIGITS = 3;

	localparam int ACC_W   = 24;
	localparam int SCALE_W = 20;
	localparam int IDC_W   = $clog2(INTEGER_DIGITS + 1);
	localparam int FDC_W   = 2;
	localparam int POS_W   = 3;
	localparam int CNT_W   = 5;
	localparam int FIELD_W = 4;

	localparam int unsigned SPEED_MAX = 32'd9999999;

	// largest accumulator value: min(10^INTEGER_DIGITS * 1000 - 1, SPEED_MAX)
	function automatic longint unsigned cap_calc();
		longint unsigned c;
		c = 64'd1000;
		for (int i = 0; i < INTEGER_DIGITS; i++) begin
			if (c <= 64'(SPEED_MAX)) begin
				c = c * 64'd10;
			end
		end
		c = c - 64'd1;
		return (c > 64'(SPEED_MAX)) ? 64'(SPEED_MAX) : c;
	endfunction

	localparam longint unsigned VALUE_CAP = cap_calc();

	// characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [POS_W-1:0] TAG_LEN = 3'd6;

	// register indexes on the config port
	localparam logic REG_FIELD_INDEX = 1'b0;
	localparam logic REG_SCALE_PPM   = 1'b1;

	localparam logic [FIELD_W-1:0] FIELD_RESET = 4'd7;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd621371;

	// sentence tag "$GNVTG"
	function automatic logic [7:0] tag_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h4E;
			3'd3: c = 8'h56;
			3'd4: c = 8'h54;
			default: c = 8'h47;
		endcase
		return c;
	endfunction

	// weight of a fraction digit in thousandths
	function automatic logic [6:0] frac_weight(input logic [FDC_W-1:0] idx);
		logic [6:0] w;
		unique case (idx)
			2'd0: w = 7'd100;
			2'd1: w = 7'd10;
			default: w = 7'd1;
		endcase
		return w;
	endfunction

	// one finished line handed from the parser to the scaler
	typedef struct packed {
		logic [ACC_W-1:0]   acc;
		logic [SCALE_W-1:0] scale;
		logic               valid;
		logic               sat;
	} line_res_t;

endpackage

### hdl/nvtg_parser.sv
module nvtg_parser
	import nvtg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [SCALE_W-1:0] cfg_data,
	input  logic               byte_take,
	input  logic [7:0]         rx_byte,
	output logic               line_done,
	output line_res_t          line_res
);

	typedef enum logic [1:0] {PH_WAIT, PH_INT, PH_FRAC, PH_DONE} phase_t;

	localparam int SUM_W = ACC_W + 4;

	logic [FIELD_W-1:0] field_q;
	logic [SCALE_W-1:0] scale_q;

	logic [POS_W-1:0] pos_q, pos_d;
	logic             match_q, match_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [IDC_W-1:0] idc_q, idc_d;
	logic [FDC_W-1:0] fdc_q, fdc_d;
	phase_t           ph_q, ph_d;
	logic             seen_q, seen_d;
	logic             clamp_q, clamp_d;

	logic             is_nl, is_digit, in_field;
	logic [3:0]       dig;
	logic [SUM_W-1:0] int_sum, frac_sum;

	assign is_nl    = (rx_byte == CH_NL);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign dig      = rx_byte[3:0];
	assign in_field = (rx_byte != CH_COMMA) && (cnt_q == {1'b0, field_q});

	// candidate accumulator values for an integer or a fraction digit
	assign int_sum  = (SUM_W'(acc_q) << 3) + (SUM_W'(acc_q) << 1)
		+ SUM_W'(dig) * SUM_W'(1000);
	assign frac_sum = SUM_W'(acc_q) + SUM_W'(dig) * SUM_W'(frac_weight(fdc_q));

	// per-character state update
	always_comb begin
		pos_d   = pos_q;
		match_d = match_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		idc_d   = idc_q;
		fdc_d   = fdc_q;
		ph_d    = ph_q;
		seen_d  = seen_q;
		clamp_d = clamp_q;
		if (is_nl) begin
			pos_d   = '0;
			match_d = 1'b1;
			cnt_d   = '0;
			acc_d   = '0;
			idc_d   = '0;
			fdc_d   = '0;
			ph_d    = PH_WAIT;
			seen_d  = 1'b0;
			clamp_d = 1'b0;
		end else begin
			// tag check over the first six characters
			if (pos_q < TAG_LEN) begin
				if (rx_byte != tag_char(pos_q)) begin
					match_d = 1'b0;
				end
				pos_d = pos_q + 1'b1;
			end
			// comma count, saturating
			if (rx_byte == CH_COMMA) begin
				if (cnt_q != '1) begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			// number gathering inside the selected field
			if (in_field) begin
				unique case (ph_q)
					PH_WAIT, PH_INT: begin
						if (is_digit) begin
							ph_d   = PH_INT;
							seen_d = 1'b1;
							if (!clamp_q && !(acc_q == '0 && dig == 4'd0)) begin
								if (idc_q >= IDC_W'(INTEGER_DIGITS)) begin
									acc_d   = ACC_W'(VALUE_CAP);
									clamp_d = 1'b1;
								end else begin
									idc_d = idc_q + 1'b1;
									if (int_sum > SUM_W'(VALUE_CAP)) begin
										acc_d   = ACC_W'(VALUE_CAP);
										clamp_d = 1'b1;
									end else begin
										acc_d = int_sum[ACC_W-1:0];
									end
								end
							end
						end else if (rx_byte == CH_DOT) begin
							ph_d = PH_FRAC;
						end else if (ph_q == PH_INT || rx_byte != CH_SPACE) begin
							ph_d = PH_DONE;
						end
					end
					PH_FRAC: begin
						if (is_digit) begin
							seen_d = 1'b1;
							if (!clamp_q && fdc_q < FDC_W'(FRACTION_DIGITS)) begin
								fdc_d = fdc_q + 1'b1;
								if (frac_sum > SUM_W'(VALUE_CAP)) begin
									acc_d   = ACC_W'(VALUE_CAP);
									clamp_d = 1'b1;
								end else begin
									acc_d = frac_sum[ACC_W-1:0];
								end
							end
						end else begin
							ph_d = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// a matched line ends at its newline
	assign line_done      = byte_take && is_nl && match_q && (pos_q == TAG_LEN);
	assign line_res.acc   = seen_q ? acc_q : '0;
	assign line_res.scale = scale_q;
	assign line_res.valid = seen_q;
	assign line_res.sat   = seen_q && clamp_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= FIELD_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FIELD_INDEX: field_q <= cfg_data[FIELD_W-1:0];
				REG_SCALE_PPM:   scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= 1'b1;
			cnt_q   <= '0;
			acc_q   <= '0;
			idc_q   <= '0;
			fdc_q   <= '0;
			ph_q    <= PH_WAIT;
			seen_q  <= 1'b0;
			clamp_q <= 1'b0;
		end else if (byte_take) begin
			pos_q   <= pos_d;
			match_q <= match_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			idc_q   <= idc_d;
			fdc_q   <= fdc_d;
			ph_q    <= ph_d;
			seen_q  <= seen_d;
			clamp_q <= clamp_d;
		end
	end

endmodule

### hdl/nvtg_scaler.sv
module nvtg_scaler
	import nvtg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  line_res_t        in_res,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ACC_W-1:0] out_speed,
	output logic             out_flag_valid,
	output logic             out_flag_sat
);

	localparam int PROD_W = ACC_W + SCALE_W;       // 44
	localparam int HI_W   = PROD_W - 12;           // product >> 12
	localparam int Q_W    = 25;
	localparam int M_W    = 25;
	localparam longint unsigned DIVISOR = 64'd1000000;
	// floor(2^44 / 10^6): quotient estimate is at most two low
	localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << 44) / DIVISOR);
	localparam int EST_W  = HI_W + M_W;
	localparam int QM_W   = Q_W + SCALE_W;

	typedef struct packed {
		logic valid;
		logic sat;
	} flags_t;

	// stage valids and back-pressure chain
	logic v1_q, v2_q, v3_q, v4_q, ov_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;

	assign rdy_out  = !ov_q || out_ready;
	assign rdy4     = !v4_q || rdy_out;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	// stage payloads
	logic [ACC_W-1:0]   acc_s1;
	logic [SCALE_W-1:0] scale_s1;
	flags_t             fl_s1, fl_s2, fl_s3, fl_s4;
	logic [PROD_W-1:0]  p_s2, p_s3, p_s4;
	logic [Q_W-1:0]     qe_s3, qe_s4;
	logic [PROD_W-1:0]  qm_s4;
	logic [ACC_W-1:0]   speed_q;
	flags_t             fl_q;

	logic [EST_W-1:0]  est;
	logic [QM_W-1:0]   qm;
	logic [PROD_W-1:0] rem;
	logic [Q_W:0]      q_fix;

	assign est   = EST_W'(p_s2[PROD_W-1:12]) * EST_W'(RECIP);
	assign qm    = QM_W'(qe_s3) * QM_W'(DIVISOR);
	assign rem   = p_s4 - qm_s4;
	assign q_fix = (Q_W+1)'(qe_s4)
		+ (Q_W+1)'(rem >= PROD_W'(DIVISOR))
		+ (Q_W+1)'(rem >= PROD_W'(2 * DIVISOR));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1)    v1_q <= in_valid;
			if (rdy2)    v2_q <= v1_q;
			if (rdy3)    v3_q <= v2_q;
			if (rdy4)    v4_q <= v3_q;
			if (rdy_out) ov_q <= v4_q;
		end
	end

	// payload: capture, multiply, estimate, back-multiply, correct and clamp
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			acc_s1   <= in_res.acc;
			scale_s1 <= in_res.scale;
			fl_s1    <= '{valid: in_res.valid, sat: in_res.sat};
		end
		if (rdy2 && v1_q) begin
			p_s2  <= PROD_W'(acc_s1) * PROD_W'(scale_s1);
			fl_s2 <= fl_s1;
		end
		if (rdy3 && v2_q) begin
			qe_s3 <= est[EST_W-1:32];
			p_s3  <= p_s2;
			fl_s3 <= fl_s2;
		end
		if (rdy4 && v3_q) begin
			qm_s4 <= qm[PROD_W-1:0];
			qe_s4 <= qe_s3;
			p_s4  <= p_s3;
			fl_s4 <= fl_s3;
		end
		if (rdy_out && v4_q) begin
			speed_q <= (q_fix > (Q_W+1)'(SPEED_MAX)) ? ACC_W'(SPEED_MAX)
				: q_fix[ACC_W-1:0];
			fl_q    <= fl_s4;
		end
	end

	assign out_valid      = ov_q;
	assign out_speed      = speed_q;
	assign out_flag_valid = fl_q.valid;
	assign out_flag_sat   = fl_q.sat;

endmodule

### hdl/nmea_vtg_speed_extractor.sv
// NMEA VTG ground speed extractor.
// Slave stream: one received character per request in s_tdata. Lines that
// start with "$GNVTG" have the field selected by register 0 (field number,
// tag is field 0) parsed as a decimal in thousandths; at the newline the
// master stream carries one request: the value times register 1 (parts per
// million), rounded down and capped at 9999999, with a valid flag (field held
// a digit) and a saturated flag. Other lines give nothing.
// Config: cfg_we writes cfg_data into register cfg_addr in the same cycle.
// Throughput: one character per cycle while s_tready is high. The result
// shows on m_tvalid after the newline is taken, through a five-register chain
// (capture, 24x20 multiply, reciprocal estimate, back-multiply, correction).
// Stall: when m_tready is low the result is held; the chain keeps filling its
// empty stages, so characters are still taken until every stage holds a
// result, then s_tready drops. Characters that end no line are taken freely
// while a stage is free.
// Reset: registers return to field 7 and scale 621371 (km/h to mph), the line
// state clears and the chain empties; no result is pending.
module nmea_vtg_speed_extractor
	import nvtg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [23:0] speed_milli
	output logic [1:0]         m_tuser,   // [0] speed_valid, [1] speed_saturated
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [SCALE_W-1:0] cfg_data
);

	logic      byte_take;
	logic      line_done;
	line_res_t line_res;

	assign byte_take = s_tvalid && s_tready;

	nvtg_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.byte_take (byte_take),
		.rx_byte   (s_tdata),
		.line_done (line_done),
		.line_res  (line_res)
	);

	nvtg_scaler u_scaler (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (line_done),
		.in_ready       (s_tready),
		.in_res         (line_res),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_speed      (m_tdata),
		.out_flag_valid (m_tuser[0]),
		.out_flag_sat   (m_tuser[1])
	);

endmodule

### hdl/nvtg_checker.sv
module nvtg_checker
	import nvtg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input is only held off behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	// an empty field gives zero speed and no saturation
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0 && !m_tuser[1])
		else $error("empty field with nonzero result");

	// the speed never exceeds the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= 24'(SPEED_MAX))
		else $error("speed above cap");

endmodule

bind nmea_vtg_speed_extractor nvtg_checker u_nvtg_checker (.*);

### tb/sv/tb_nmea_vtg_speed_extractor.sv
module tb_nmea_vtg_speed_extractor;
	import nvtg_pkg::*;

	localparam int CLK_HALF = 10;
	localparam longint unsigned RUN_LIMIT = 64'd20_000_000;

	// largest speed held in thousandths: min(10^INTEGER_DIGITS * 1000 - 1, SPEED_MAX)
	localparam longint unsigned FULL_SCALE = (64'd10 ** INTEGER_DIGITS) * 64'd1000 - 64'd1;
	localparam longint unsigned ACC_LIMIT =
		(FULL_SCALE > 64'(SPEED_MAX)) ? 64'(SPEED_MAX) : FULL_SCALE;

	localparam string NMEA_TAG = "$GNVTG";
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	typedef enum logic [1:0] {NUM_WAIT, NUM_INT, NUM_FRAC, NUM_DONE} num_phase_t;

	// Tracks the line parser and holds the speeds still owed by the block
	class speed_board;
		typedef struct packed {
			logic [23:0] speed;
			logic        valid;
			logic        sat;
		} speed_res_t;

		bit [3:0]    field_sel;
		bit [19:0]   scale;
		bit [2:0]    tag_pos;
		bit          tag_ok;
		bit [4:0]    commas;
		bit [23:0]   acc;
		int unsigned int_digits;
		int unsigned frac_digits;
		num_phase_t  phase;
		bit          got_digit;
		bit          clamped;

		speed_res_t expected_speeds[$];
		int errors;
		int checked;
		int with_speed;
		int clamped_results;

		function new();
			field_sel = FIELD_RESET;
			scale = SCALE_RESET;
			clear_line();
		endfunction

		function void clear_line();
			tag_pos = 0;
			tag_ok = 1'b1;
			commas = 0;
			acc = 0;
			int_digits = 0;
			frac_digits = 0;
			phase = NUM_WAIT;
			got_digit = 1'b0;
			clamped = 1'b0;
		endfunction

		// one accepted character request
		function void note_char(logic [7:0] c);
			speed_res_t res;
			longint unsigned prod;
			longint unsigned nxt;
			longint unsigned wt;
			int unsigned d;
			bit is_digit;
			if (c == CH_NL) begin
				if (tag_ok && tag_pos >= TAG_LEN) begin
					prod = 0;
					if (got_digit) begin
						prod = 64'(acc) * 64'(scale) / 64'd1000000;
						if (prod > 64'(SPEED_MAX))
							prod = 64'(SPEED_MAX);
					end
					res.speed = prod[23:0];
					res.valid = got_digit;
					res.sat = got_digit && clamped;
					expected_speeds.insert(expected_speeds.size(), res);
				end
				clear_line();
				return;
			end

			if (tag_pos < TAG_LEN) begin
				if (c != NMEA_TAG[tag_pos])
					tag_ok = 1'b0;
				tag_pos++;
			end

			if (c == CH_COMMA) begin
				if (commas != 5'd31)
					commas++;
			end else if (commas == {1'b0, field_sel}) begin
				is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
				d = c - CH_ZERO;
				if (is_digit && (phase == NUM_WAIT || phase == NUM_INT)) begin
					// integer part; leading zeros do not count as digits
					got_digit = 1'b1;
					phase = NUM_INT;
					if (!clamped && !(acc == 0 && d == 0)) begin
						if (int_digits >= INTEGER_DIGITS) begin
							acc = 24'(ACC_LIMIT);
							clamped = 1'b1;
						end else begin
							nxt = 64'(acc) * 64'd10 + 64'(d) * 64'd1000;
							int_digits++;
							if (nxt > ACC_LIMIT) begin
								acc = 24'(ACC_LIMIT);
								clamped = 1'b1;
							end else begin
								acc = nxt[23:0];
							end
						end
					end
				end else if (is_digit && phase == NUM_FRAC) begin
					// fraction part; extra digits are truncated
					got_digit = 1'b1;
					if (!clamped && frac_digits < FRACTION_DIGITS && frac_digits < 3) begin
						wt = (frac_digits == 0) ? 64'd100 : (frac_digits == 1) ? 64'd10 : 64'd1;
						nxt = 64'(acc) + 64'(d) * wt;
						frac_digits++;
						if (nxt > ACC_LIMIT) begin
							acc = 24'(ACC_LIMIT);
							clamped = 1'b1;
						end else begin
							acc = nxt[23:0];
						end
					end
				end else if (c == CH_DOT && (phase == NUM_WAIT || phase == NUM_INT)) begin
					phase = NUM_FRAC;
				end else if (!(c == CH_SPACE && phase == NUM_WAIT)) begin
					phase = NUM_DONE;
				end
			end
		endfunction

		// one result request from the block
		function void check_result(logic [23:0] speed, logic [1:0] flags);
			speed_res_t want;
			if (expected_speeds.size() == 0) begin
				$display("%0t: result with none expected: speed %0d valid %b saturated %b",
					$time, speed, flags[0], flags[1]);
				errors++;
				return;
			end
			want = expected_speeds.pop_front();
			checked++;
			if (want.valid)
				with_speed++;
			if (want.sat)
				clamped_results++;
			if (speed !== want.speed) begin
				$display("%0t: speed_milli expected %0d, got %0d", $time, want.speed, speed);
				errors++;
			end
			if (flags[0] !== want.valid) begin
				$display("%0t: speed_valid expected %b, got %b", $time, want.valid, flags[0]);
				errors++;
			end
			if (flags[1] !== want.sat) begin
				$display("%0t: speed_saturated expected %b, got %b", $time, want.sat, flags[1]);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [23:0]         m_tdata;
	logic [1:0]          m_tuser;
	logic                cfg_we = 1'b0;
	logic                cfg_addr = 1'b0;
	logic [SCALE_W-1:0]  cfg_data = '0;

	speed_board sb;
	bit       calm = 1'b0;
	int       hold_left = 0;
	int       rx_stall = 0;
	int       chars_sent = 0;
	int       stall_cycles = 0;
	int       settings = 0;
	bit [3:0] cur_field = FIELD_RESET;

	nmea_vtg_speed_extractor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// mostly back to back, sometimes a short gap, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic bit [7:0] rand_byte();
		bit [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == CH_NL) ? 8'h0B : b;
	endfunction

	// result side: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if (!calm)
				rx_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_char(input bit [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) begin
			stall_cycles++;
			@(posedge clk);
		end
		sb.note_char(c);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// stop sending and let every owed result come out
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (sb.expected_speeds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_regs(input bit [3:0] field, input bit [19:0] ppm);
		cfg_we <= 1'b1;
		cfg_addr <= REG_FIELD_INDEX;
		cfg_data <= SCALE_W'(field);
		@(posedge clk);
		sb.field_sel = field;
		@(negedge clk);
		cfg_addr <= REG_SCALE_PPM;
		cfg_data <= ppm;
		@(posedge clk);
		sb.scale = ppm;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_field = field;
		settings++;
	endtask

	// random sentences, mostly well formed with random field contents
	task automatic run_phase(input int budget);
		int start;
		int kind;
		int nf;
		int n;
		bit [7:0] line_buf[$];
		start = chars_sent;
		while (chars_sent - start < budget) begin
			line_buf.delete();
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				n = $urandom_range(1, 12);
				repeat (n) line_buf.insert(line_buf.size(), rand_byte());
			end else if (kind < 11) begin
				// line ends inside the tag
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					line_buf.insert(line_buf.size(), NMEA_TAG[i]);
			end else begin
				for (int i = 0; i < 6; i++)
					line_buf.insert(line_buf.size(), NMEA_TAG[i]);
				if (kind < 21)
					line_buf[$urandom_range(0, 5)] = rand_byte();
				n = $urandom_range(0, 99);
				if (n < 8)
					nf = $urandom_range(0, cur_field);
				else if (n < 12)
					nf = $urandom_range(30, 34);
				else
					nf = cur_field + $urandom_range(0, 3);
				for (int f = 1; f <= nf; f++) begin
					line_buf.insert(line_buf.size(), CH_COMMA);
					if (f == cur_field) begin
						if ($urandom_range(0, 3) == 0)
							repeat ($urandom_range(1, 2))
								line_buf.insert(line_buf.size(), CH_SPACE);
						if ($urandom_range(0, 19) == 0)
							line_buf.insert(line_buf.size(),
								$urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
						if ($urandom_range(0, 7) == 0)
							repeat ($urandom_range(1, 3))
								line_buf.insert(line_buf.size(), CH_ZERO);
						n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
						repeat (n)
							line_buf.insert(line_buf.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
						if ($urandom_range(0, 9) < 7) begin
							line_buf.insert(line_buf.size(), CH_DOT);
							n = $urandom_range(0, 5);
							repeat (n)
								line_buf.insert(line_buf.size(),
									8'(CH_ZERO + $urandom_range(0, 9)));
						end
						if ($urandom_range(0, 4) == 0)
							repeat ($urandom_range(1, 3))
								line_buf.insert(line_buf.size(), rand_byte());
					end else begin
						n = $urandom_range(0, 4);
						repeat (n) begin
							case ($urandom_range(0, 3))
								0: line_buf.insert(line_buf.size(),
									8'(CH_ZERO + $urandom_range(0, 9)));
								1: line_buf.insert(line_buf.size(),
									8'(CH_UPPER_A + $urandom_range(0, 25)));
								2: line_buf.insert(line_buf.size(), CH_DOT);
								default: line_buf.insert(line_buf.size(), rand_byte());
							endcase
						end
					end
				end
				if ($urandom_range(0, 9) == 0)
					line_buf.insert(line_buf.size(), CH_CR);
			end
			line_buf.insert(line_buf.size(), CH_NL);
			foreach (line_buf[i])
				send_char(line_buf[i]);
		end
		wait_drain();
	endtask

	initial begin
		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: field 7, km/h to mph
		run_phase(200);

		// directed sentences on field 1 at unit scale
		set_regs(4'd1, 20'd1000000);
		send_text("$GNVTG,0009999.9999x\r\n");
		send_text("$GNVTG, 123456\n");
		send_text("$GNVTG,-5\n");
		send_text("$GNVTG,.5\n");
		send_text("$GNVTG\n");
		send_text("$GNVTG,,3\n");
		send_text("$GNVT\n");
		send_text("$GPVTG,");
		send_char(8'hFF);
		send_char(8'h00);
		send_text("12\n");
		send_text("$GNVTG,7.25,N,1\r\n");
		wait_drain();
		// scale extremes: product saturation, then zero
		set_regs(4'd1, 20'hFFFFF);
		send_text("$GNVTG,9999.999\n");
		wait_drain();
		set_regs(4'd1, 20'd0);
		send_text("$GNVTG,42\n");
		wait_drain();

		// long result hold-off while characters keep coming
		set_regs(4'd1, SCALE_RESET);
		calm = 1'b1;
		hold_left = 400;
		repeat (14) send_text("$GNVTG,12.5\n");
		calm = 1'b0;
		wait_drain();

		set_regs(4'd0, 20'd0);
		run_phase(200);
		set_regs(4'd15, 20'hFFFFF);
		run_phase(260);
		set_regs(4'd1, 20'd1000000);
		calm = 1'b1;
		run_phase(200);
		calm = 1'b0;
		repeat (4) begin
			set_regs(4'($urandom_range(1, 9)), 20'($urandom_range(0, 20'hFFFFF)));
			run_phase(150);
		end

		$display("Sent %0d characters under %0d register settings; input held off %0d cycles.",
			chars_sent, settings, stall_cycles);
		$display("Checked %0d speeds: %0d with a number, %0d clamped, %0d mismatches.",
			sb.checked, sb.with_speed, sb.clamped_results, sb.errors);
		if (sb.errors == 0 && sb.expected_speeds.size() == 0) begin
			$display("** nmea_vtg_speed_extractor: PASSED **");
		end else begin
			$display("** nmea_vtg_speed_extractor: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT);
		$display("** nmea_vtg_speed_extractor: FAILED **");
		$finish;
	end

endmodule

### files.f
hdl/nvtg_pkg.sv
hdl/nvtg_parser.sv
hdl/nvtg_scaler.sv
hdl/nmea_vtg_speed_extractor.sv
hdl/nvtg_checker.sv
tb/sv/tb_nmea_vtg_speed_extractor.sv
